// ----- rtl/dtdw_pkg.sv -----
package dtdw_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DNUM_W  = 22;
	localparam int WDAY_W  = 3;
	localparam int DOY_W   = 9;
	localparam int LEAPS_W = 12;

	// month codes
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
	localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 14'd1970;
	localparam logic [YEAR_W-1:0]  MAX_YEAR      = 14'd9999;
	localparam logic [YEAR_W-1:0]  CENTURY       = 14'd100;
	localparam logic [DNUM_W-1:0]  DAYS_PER_YEAR = 22'd365;
	localparam logic [WDAY_W-1:0]  EPOCH_WEEKDAY = 3'd4;
	localparam logic [LEAPS_W-1:0] LEAPS_BEFORE_EPOCH = 12'd477;

	// floor(y/100) = (y * 5243) >> 19 for any 14-bit y
	localparam int                 RECIP100_W = 13;
	localparam logic [RECIP100_W-1:0] RECIP_100 = 13'd5243;
	localparam int                 SHIFT_100  = 19;
	localparam int                 DIV100_W   = 8;
	localparam int                 PROD100_W  = YEAR_W + RECIP100_W;

	// floor(x/7) = (x * 9586981) >> 26 for any 23-bit x
	localparam int                 MOD7_X_W  = DNUM_W + 1;
	localparam int                 RECIP7_W  = 24;
	localparam logic [RECIP7_W-1:0] RECIP_7  = 24'd9586981;
	localparam int                 SHIFT_7   = 26;
	localparam int                 PROD7_W   = MOD7_X_W + RECIP7_W;
	localparam int                 DIV7_W    = PROD7_W - SHIFT_7;
	localparam logic [MOD7_X_W-1:0] SEVEN    = 23'd7;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_off;
		logic [LEAPS_W-1:0] leaps;
		logic [DOY_W-1:0]   day_of_year;
		logic               date_valid;
		logic               before_epoch;
		logic               ok;
	} cal_t;

	typedef struct packed {
		logic [DNUM_W-1:0] day_number;
		logic              date_valid;
		logic              before_epoch;
		logic              ok;
	} cnt_t;

	// days before the first of the month in a common year
	function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] r;
		case (m)
			MON_JAN: r = 9'd0;
			MON_FEB: r = 9'd31;
			MON_MAR: r = 9'd59;
			MON_APR: r = 9'd90;
			MON_MAY: r = 9'd120;
			MON_JUN: r = 9'd151;
			MON_JUL: r = 9'd181;
			MON_AUG: r = 9'd212;
			MON_SEP: r = 9'd243;
			MON_OCT: r = 9'd273;
			MON_NOV: r = 9'd304;
			MON_DEC: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] r;
		case (m) inside
			MON_FEB: r = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dtdw_calendar.sv -----
module dtdw_calendar (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [dtdw_pkg::YEAR_W-1:0]      year,
	input  logic [dtdw_pkg::MONTH_W-1:0]     month,
	input  logic [dtdw_pkg::DAY_W-1:0]       day_of_month,
	output logic                             out_valid,
	input  logic                             out_ready,
	output dtdw_pkg::cal_t                   out_data
);
	import dtdw_pkg::*;

	// stage 1: century reciprocal products and range flags
	logic                  v_s1;
	logic [YEAR_W-1:0]     year_s1;
	logic [MONTH_W-1:0]    month_s1;
	logic [DAY_W-1:0]      day_s1;
	logic [PROD100_W-1:0]  prod_s1;
	logic [PROD100_W-1:0]  prodn_s1;
	logic                  mon_ok_s1;
	logic                  early_s1;
	logic                  over_s1;

	// stage 2
	logic                  v_s2;
	cal_t                  cal_s2;

	logic                  ready_s1;
	logic                  ready_s2;
	logic [YEAR_W-1:0]     year_m1;

	logic [DIV100_W-1:0]   q100;
	logic [DIV100_W-1:0]   q100n;
	logic [YEAR_W-1:0]     yprev;
	logic [YEAR_W-1:0]     r100;
	logic                  leap;
	logic [LEAPS_W-1:0]    leaps_n;
	logic [DAY_W-1:0]      mlen;
	logic                  dvalid;
	cal_t                  cal_d;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign year_m1  = year - YEAR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			year_s1   <= year;
			month_s1  <= month;
			day_s1    <= day_of_month;
			prod_s1   <= PROD100_W'(year) * PROD100_W'(RECIP_100);
			prodn_s1  <= PROD100_W'(year_m1) * PROD100_W'(RECIP_100);
			mon_ok_s1 <= (month >= MON_JAN) && (month <= MON_DEC);
			early_s1  <= year < EPOCH_YEAR;
			over_s1   <= year > MAX_YEAR;
		end
	end

	// leap rule, leap count up to last year, date check, day of year
	always_comb begin
		q100    = prod_s1[SHIFT_100 +: DIV100_W];
		q100n   = prodn_s1[SHIFT_100 +: DIV100_W];
		yprev   = year_s1 - YEAR_W'(1);
		r100    = year_s1 - YEAR_W'(YEAR_W'(q100) * CENTURY);
		leap    = ((year_s1[1:0] == 2'd0) && (r100 != '0)) ||
			((r100 == '0) && (q100[1:0] == 2'd0));
		leaps_n = LEAPS_W'(yprev >> 2) - LEAPS_W'(q100n) + LEAPS_W'(q100n >> 2);
		mlen    = month_length(month_s1, leap);
		dvalid  = mon_ok_s1 && (day_s1 != '0) && (day_s1 <= mlen);

		cal_d.year_off     = year_s1 - EPOCH_YEAR;
		cal_d.leaps        = leaps_n - LEAPS_BEFORE_EPOCH;
		cal_d.day_of_year  = days_before_month(month_s1) + DOY_W'(day_s1) +
			DOY_W'(leap && (month_s1 > MON_FEB));
		cal_d.date_valid   = dvalid;
		cal_d.before_epoch = early_s1;
		cal_d.ok           = dvalid && !early_s1 && !over_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			cal_s2 <= cal_d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = cal_s2;

endmodule

// ----- rtl/dtdw_day_count.sv -----
module dtdw_day_count (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dtdw_pkg::cal_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dtdw_pkg::cnt_t out_data
);
	import dtdw_pkg::*;

	logic              v_s3;
	cnt_t              cnt_s3;
	logic [DNUM_W-1:0] dn;
	cnt_t              cnt_d;

	assign in_ready = !v_s3 || out_ready;

	// whole years, leap days, then day within the year
	always_comb begin
		dn = DNUM_W'(in_data.year_off) * DAYS_PER_YEAR + DNUM_W'(in_data.leaps) +
			DNUM_W'(in_data.day_of_year) - DNUM_W'(1);
		cnt_d.day_number   = in_data.ok ? dn : '0;
		cnt_d.date_valid   = in_data.date_valid;
		cnt_d.before_epoch = in_data.before_epoch;
		cnt_d.ok           = in_data.ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cnt_s3 <= cnt_d;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = cnt_s3;

endmodule

// ----- rtl/dtdw_weekday.sv -----
module dtdw_weekday (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dtdw_pkg::cnt_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dtdw_pkg::DNUM_W-1:0]   day_number,
	output logic [dtdw_pkg::WDAY_W-1:0]   weekday,
	output logic                          date_valid,
	output logic                          before_epoch
);
	import dtdw_pkg::*;

	// stage 4: reciprocal product for the mod 7
	logic                 v_s4;
	logic [PROD7_W-1:0]   prod_s4;
	logic [MOD7_X_W-1:0]  x_s4;
	cnt_t                 cnt_s4;

	// stage 5: output register
	logic                 v_s5;
	logic [DNUM_W-1:0]    day_number_s5;
	logic [WDAY_W-1:0]    weekday_s5;
	logic                 date_valid_s5;
	logic                 before_epoch_s5;

	logic                 ready_s4;
	logic                 ready_s5;
	logic [MOD7_X_W-1:0]  x;
	logic [DIV7_W-1:0]    q7;
	logic [MOD7_X_W-1:0]  rem7;

	assign ready_s5 = !v_s5 || out_ready;
	assign ready_s4 = !v_s4 || ready_s5;
	assign in_ready = ready_s4;

	assign x    = MOD7_X_W'(in_data.day_number) + MOD7_X_W'(EPOCH_WEEKDAY);
	assign q7   = prod_s4[SHIFT_7 +: DIV7_W];
	assign rem7 = x_s4 - MOD7_X_W'(MOD7_X_W'(q7) * SEVEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ready_s4) begin
				v_s4 <= in_valid;
			end
			if (ready_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s4) begin
			prod_s4 <= PROD7_W'(x) * PROD7_W'(RECIP_7);
			x_s4    <= x;
			cnt_s4  <= in_data;
		end
		if (v_s4 && ready_s5) begin
			day_number_s5   <= cnt_s4.day_number;
			weekday_s5      <= cnt_s4.ok ? rem7[WDAY_W-1:0] : '0;
			date_valid_s5   <= cnt_s4.date_valid;
			before_epoch_s5 <= cnt_s4.before_epoch;
		end
	end

	assign out_valid    = v_s5;
	assign day_number   = day_number_s5;
	assign weekday      = weekday_s5;
	assign date_valid   = date_valid_s5;
	assign before_epoch = before_epoch_s5;

endmodule

// ----- rtl/date_to_day_number_weekday.sv -----
// channel   handshake              word
// request   req_valid, req_ready   year, month, day_of_month
// response  rsp_valid, rsp_ready   day_number, weekday, date_valid, before_epoch
//
// five register stages, one word per cycle sustained while rsp_ready stays high
// stages: century products, leap rule and day of year, day count, mod 7 product, remainder
// each stage has its own ready, so a stalled response stops only the full
// stages behind it and bubbles still close up
// arst_n clears the stage valid bits only; payload registers are not reset
module date_to_day_number_weekday (
	input  logic                          clk,
	input  logic                          arst_n,
	// request words
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [dtdw_pkg::YEAR_W-1:0]   year,
	input  logic [dtdw_pkg::MONTH_W-1:0]  month,
	input  logic [dtdw_pkg::DAY_W-1:0]    day_of_month,
	// response words
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [dtdw_pkg::DNUM_W-1:0]   day_number,
	output logic [dtdw_pkg::WDAY_W-1:0]   weekday,
	output logic                          date_valid,
	output logic                          before_epoch
);
	import dtdw_pkg::*;

	// calendar to day count
	logic cal_valid;
	logic cal_ready;
	cal_t cal_data;

	// day count to weekday
	logic cnt_valid;
	logic cnt_ready;
	cnt_t cnt_data;

	// stages 1-2: leap rule, leap count since epoch, date check, day of year
	dtdw_calendar u_calendar (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req_valid),
		.in_ready     (req_ready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.out_valid    (cal_valid),
		.out_ready    (cal_ready),
		.out_data     (cal_data)
	);

	// stage 3: days since epoch, forced to zero on any error
	dtdw_day_count u_day_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cal_valid),
		.in_ready  (cal_ready),
		.in_data   (cal_data),
		.out_valid (cnt_valid),
		.out_ready (cnt_ready),
		.out_data  (cnt_data)
	);

	// stages 4-5: weekday by reciprocal mod 7, epoch is a thursday
	dtdw_weekday u_weekday (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cnt_valid),
		.in_ready     (cnt_ready),
		.in_data      (cnt_data),
		.out_valid    (rsp_valid),
		.out_ready    (rsp_ready),
		.day_number   (day_number),
		.weekday      (weekday),
		.date_valid   (date_valid),
		.before_epoch (before_epoch)
	);

endmodule

// ----- tb/tb_date_to_day_number_weekday.sv -----
module tb_date_to_day_number_weekday;
	timeunit 1ns;
	timeprecision 1ps;

	import dtdw_pkg::*;

	// month codes with no calendar name, all of them invalid
	localparam logic [MONTH_W-1:0] MON_ZERO     = 4'd0;
	localparam logic [MONTH_W-1:0] MON_PAST_DEC = 4'd13;
	localparam logic [MONTH_W-1:0] MON_TOP      = 4'd15;

	localparam int RANDOM_WORDS = 900;
	// five stages plus margin once the last word has drained
	localparam int DRAIN_CYCLES = 20;
	// worst word: long request gap, long response stall, pipeline depth; taken ~5x
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_PRINTS   = 100;

	// one response word as the checker sees it
	typedef struct packed {
		logic [DNUM_W-1:0] day_number;
		logic [WDAY_W-1:0] weekday;
		logic              date_valid;
		logic              before_epoch;
	} day_answer_t;

	// one directed row: the date, and an answer typed in where it is obvious
	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               typed;
		day_answer_t        answer;
	} date_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day_of_month;
	logic rsp_valid;
	logic rsp_ready;
	logic [DNUM_W-1:0] day_number;
	logic [WDAY_W-1:0] weekday;
	logic date_valid;
	logic before_epoch;

	// answer that goes with the request word now on the port
	day_answer_t word_answer;
	// answers of accepted words still waiting for their response, oldest first
	day_answer_t expected_days[$];
	date_row_t   directed_dates[$];

	int  mismatches  = 0;
	int  cycle_count = 0;
	// while set, neither side idles
	logic steady = 1'b0;

	date_to_day_number_weekday i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.day_number   (day_number),
		.weekday      (weekday),
		.date_valid   (date_valid),
		.before_epoch (before_epoch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// calendar predictor
	// ---------------------------------------------------------------

	// gregorian 4/100/400 rule
	function automatic logic is_leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// leap years in 1..n
	function automatic int leaps_upto(input int n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	// length of month m in year y; invalid months count as 31 like the block
	function automatic int month_days(input int y, input logic [MONTH_W-1:0] m);
		case (m)
			MON_FEB: return is_leap_year(y) ? 29 : 28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
			default: return 31;
		endcase
	endfunction

	// days in the months ahead of m in a common year, summed month by month
	function automatic int days_ahead(input logic [MONTH_W-1:0] m);
		int total;
		total = 0;
		for (int k = int'(MON_JAN); k < int'(m); k++)
			total += month_days(1, MONTH_W'(k));
		return total;
	endfunction

	// full response word for one date
	function automatic day_answer_t date_answer(input logic [YEAR_W-1:0] y,
		input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
		int yi;
		int epoch;
		int doy;
		int dn;
		day_answer_t a;
		yi    = int'(y);
		epoch = int'(EPOCH_YEAR);
		a     = '0;
		a.date_valid   = (m >= MON_JAN) && (m <= MON_DEC) && (d != '0)
			&& (int'(d) <= month_days(yi, m));
		a.before_epoch = (yi < epoch);
		// day count only for valid dates inside 1970..9999
		if (a.date_valid && !a.before_epoch && yi <= int'(MAX_YEAR)) begin
			doy = days_ahead(m) + int'(d);
			if (m > MON_FEB && is_leap_year(yi))
				doy++;
			dn = (yi - epoch) * int'(DAYS_PER_YEAR) + leaps_upto(yi - 1)
				- leaps_upto(epoch - 1) + doy - 1;
			a.day_number = DNUM_W'(dn);
			a.weekday    = WDAY_W'((int'(EPOCH_WEEKDAY) + dn) % 7);
		end
		return a;
	endfunction

	// ---------------------------------------------------------------
	// helpers for stimulus and checking
	// ---------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// year mix: mostly the counted range, with the epoch, century edges,
	// pre-epoch and the above-range years all visited
	function automatic logic [YEAR_W-1:0] pick_year();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return YEAR_W'($urandom_range(int'(EPOCH_YEAR), int'(MAX_YEAR)));
		if (r < 55)
			return YEAR_W'($urandom_range(int'(EPOCH_YEAR), 2100));
		if (r < 68)
			return YEAR_W'(100 * $urandom_range(20, 100) - 1 + $urandom_range(0, 2));
		if (r < 80)
			return YEAR_W'($urandom_range(0, int'(EPOCH_YEAR) - 1));
		if (r < 90)
			return YEAR_W'($urandom_range(int'(MAX_YEAR) + 1, 16383));
		return YEAR_W'($urandom_range(0, 16383));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got,
				want);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	task automatic add_typed(input int y, input logic [MONTH_W-1:0] m, input int d,
		input int dn, input int wd, input logic v, input logic e);
		date_row_t row;
		row.year   = YEAR_W'(y);
		row.month  = m;
		row.day    = DAY_W'(d);
		row.typed  = 1'b1;
		row.answer = '{day_number: DNUM_W'(dn), weekday: WDAY_W'(wd), date_valid: v,
			before_epoch: e};
		directed_dates.push_back(row);
	endtask

	task automatic add_predicted(input int y, input logic [MONTH_W-1:0] m, input int d);
		date_row_t row;
		row.year   = YEAR_W'(y);
		row.month  = m;
		row.day    = DAY_W'(d);
		row.typed  = 1'b0;
		row.answer = '0;
		directed_dates.push_back(row);
	endtask

	// present one request word at a falling edge and hold it until taken;
	// returns at the falling edge after the accepting rising edge
	task automatic offer_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0] d, input day_answer_t a);
		int gap;
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		year         = y;
		month        = m;
		day_of_month = d;
		word_answer  = a;
		req_valid    = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// response side back pressure
	// ---------------------------------------------------------------
	initial begin : rsp_side
		int hold;
		hold      = 0;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (steady) begin
				rsp_ready = 1'b1;
				hold      = 0;
			end else if (hold > 0) begin
				rsp_ready = 1'b0;
				hold--;
			end else begin
				rsp_ready = 1'b1;
				// a stall now and then, starting on the next falling edge
				if ($urandom_range(0, 3) == 0)
					hold = pause_len();
			end
		end
	end

	// ---------------------------------------------------------------
	// scoreboard: log accepted words, match responses in order
	// ---------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		day_answer_t want;
		if (arst_n) begin
			// log first so a response can never overtake its own request
			if (req_valid && req_ready)
				expected_days.push_back(word_answer);
			if (rsp_valid && rsp_ready) begin
				if (expected_days.size() == 0) begin
					report_mismatch("response word with nothing pending", int'(day_number), 0);
				end else begin
					want = expected_days.pop_front();
					check_field("day_number", int'(day_number), int'(want.day_number));
					check_field("weekday", int'(weekday), int'(want.weekday));
					check_field("date_valid", int'(date_valid), int'(want.date_valid));
					check_field("before_epoch", int'(before_epoch), int'(want.before_epoch));
				end
			end
		end
	end

	// hard stop
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		int r;

		arst_n       = 1'b0;
		req_valid    = 1'b0;
		year         = '0;
		month        = '0;
		day_of_month = '0;
		word_answer  = '0;

		// directed rows; typed answers where they are plain to see
		add_typed(1970, MON_JAN, 1, 0, 4, 1'b1, 1'b0);      // the epoch, a thursday
		add_typed(1970, MON_JAN, 2, 1, 5, 1'b1, 1'b0);
		add_typed(1970, MON_DEC, 31, 364, 4, 1'b1, 1'b0);
		add_typed(1969, MON_DEC, 31, 0, 0, 1'b1, 1'b1);     // last day before epoch
		add_typed(0, MON_JAN, 1, 0, 0, 1'b1, 1'b1);         // lowest year
		add_typed(0, MON_FEB, 29, 0, 0, 1'b1, 1'b1);        // year 0 divides by 400
		add_typed(1900, MON_FEB, 29, 0, 0, 1'b0, 1'b1);     // century, not leap
		add_typed(2100, MON_FEB, 29, 0, 0, 1'b0, 1'b0);
		add_typed(2023, MON_FEB, 29, 0, 0, 1'b0, 1'b0);
		add_typed(2000, MON_ZERO, 1, 0, 0, 1'b0, 1'b0);     // month zero
		add_typed(2000, MON_PAST_DEC, 1, 0, 0, 1'b0, 1'b0);
		add_typed(2000, MON_TOP, 31, 0, 0, 1'b0, 1'b0);
		add_typed(2000, MON_JAN, 0, 0, 0, 1'b0, 1'b0);      // day zero
		add_typed(2001, MON_APR, 31, 0, 0, 1'b0, 1'b0);     // one past a 30 day month
		add_typed(10000, MON_JAN, 1, 0, 0, 1'b1, 1'b0);     // just above the counted range
		add_typed(16000, MON_FEB, 29, 0, 0, 1'b1, 1'b0);
		add_typed(16383, MON_DEC, 31, 0, 0, 1'b1, 1'b0);    // every year bit high
		add_typed(16383, MON_TOP, 31, 0, 0, 1'b0, 1'b0);
		add_predicted(2000, MON_FEB, 29);                   // 400 year leap
		add_predicted(2024, MON_FEB, 29);
		add_predicted(2024, MON_MAR, 1);                    // leap day pushes march on
		add_predicted(2001, MON_APR, 30);
		add_predicted(1999, MON_DEC, 31);
		add_predicted(2038, MON_JAN, 19);
		add_predicted(9999, MON_DEC, 31);                   // largest day number

		// reset asserted from the start, released on a falling edge
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, back to back so the pipeline fills
		steady = 1'b1;
		foreach (directed_dates[i]) begin
			offer_date(directed_dates[i].year, directed_dates[i].month, directed_dates[i].day,
				directed_dates[i].typed ? directed_dates[i].answer :
				date_answer(directed_dates[i].year, directed_dates[i].month,
				directed_dates[i].day));
		end

		// random part; every third block of 150 words runs with no idling
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady = ((n / 150) % 3 == 1);
			y = pick_year();
			// mostly real months, some out of range codes
			m = ($urandom_range(0, 99) < 88) ? MONTH_W'($urandom_range(int'(MON_JAN),
				int'(MON_DEC))) : MONTH_W'($urandom_range(0, 15));
			// mostly days inside the month, some on the last day or one past it, some anywhere in the field
			r = $urandom_range(0, 99);
			if (r < 70)
				d = DAY_W'($urandom_range(1, month_days(int'(y), m)));
			else if (r < 80)
				d = DAY_W'(month_days(int'(y), m) + $urandom_range(0, 1));
			else
				d = DAY_W'($urandom_range(0, 31));
			offer_date(y, m, d, date_answer(y, m, d));
		end
		steady    = 1'b0;
		req_valid = 1'b0;

		// drain
		while (expected_days.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_days.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- date_to_day_number_weekday.f -----
rtl/dtdw_pkg.sv
rtl/dtdw_calendar.sv
rtl/dtdw_day_count.sv
rtl/dtdw_weekday.sv
rtl/date_to_day_number_weekday.sv
tb/tb_date_to_day_number_weekday.sv
